// ----- design/swr_pkg.sv -----
// ----------------------------------------------------------------------------
// swr_pkg: shared types and constants for the sliding window RMS block
// Holds the default sizes, the width helpers used on the module ports, the
// control bundle between the front and back parts, and the sequencer states.
// ----------------------------------------------------------------------------
package swr_pkg;

  // Default sizes of the window and of one sample.
  localparam int DEF_WINDOW_SIZE  = 64;
  localparam int DEF_SAMPLE_WIDTH = 16;

  // Depth of the request queue between the front and back parts.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  // Width of a window index; a one-entry window still gets one bit.
  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // Width of a count that runs from zero up to the window size itself.
  function automatic int cnt_w(input int n);
    return $clog2(n + 1);
  endfunction

  // Status of the head of the request queue, as seen by the back part.
  typedef struct packed {
    logic valid;   // a request waits at the head of the queue
    logic evict;   // the window was full, so the oldest sample leaves
  } swr_ctl_t;

  // Sequencer states of the back part.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SQ_OLD,
    ST_SQ_NEW,
    ST_ACC,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } swr_state_t;

endpackage

// ----- design/sliding_window_rms.sv -----
// ----------------------------------------------------------------------------
// sliding_window_rms: running RMS over a sliding window of signed samples
//
//   Channel  Direction  Handshake            Payload
//   in       request    in_valid/in_stall    in_sample (signed)
//   out      result     out_valid/out_stall  out_rms_value, out_window_full
//
// The back part takes one request at a time: fetch, square old and new, sum,
// a bit-serial divide over SUM_W = 2*SAMPLE_WIDTH - 1 + clog2(WINDOW_SIZE)
// quotient bits, then a digit-serial square root, before it takes the next.
// The front queue holds two requests, so intake continues while one is busy.
// Reset is synchronous and clears the sum, fill count and write index; the
// window store is not cleared, as a slot's old value is only used once written.
// A stalled result waits in the output register and holds the sequencer.
// ----------------------------------------------------------------------------
module sliding_window_rms #(
  parameter int WINDOW_SIZE  = swr_pkg::DEF_WINDOW_SIZE,
  parameter int SAMPLE_WIDTH = swr_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic        [SAMPLE_WIDTH-1:0] out_rms_value,
  output logic                           out_window_full
);
  import swr_pkg::*;

  localparam int IDX_W = idx_w(WINDOW_SIZE);
  localparam int CNT_W = cnt_w(WINDOW_SIZE);

  swr_ctl_t                q_ctl;
  logic [SAMPLE_WIDTH-1:0] q_sample;
  logic [IDX_W-1:0]        q_idx;
  logic [CNT_W-1:0]        q_div;
  logic                    q_pop;

  // Intake, classification and request queue.
  swr_front #(
    .WINDOW_SIZE  (WINDOW_SIZE),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .q_ctl     (q_ctl),
    .q_sample  (q_sample),
    .q_idx     (q_idx),
    .q_div     (q_div),
    .q_pop     (q_pop)
  );

  // Window store, sum of squares, divider and square root.
  swr_back #(
    .WINDOW_SIZE  (WINDOW_SIZE),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_ctl           (q_ctl),
    .q_sample        (q_sample),
    .q_idx           (q_idx),
    .q_div           (q_div),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_rms_value   (out_rms_value),
    .out_window_full (out_window_full)
  );

  // The back part only takes a request that is waiting in the queue.
  a_pop_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_ctl.valid)
    else $error("request taken from an empty queue");

  // Once the window has filled, every later result reports it as full.
  a_full_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    out_window_full |=> out_window_full)
    else $error("window full flag dropped");

  // The root of a mean square never exceeds the full-scale magnitude.
  a_rms_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rms_value <= (SAMPLE_WIDTH'(1) << (SAMPLE_WIDTH - 1))))
    else $error("rms value above full scale");

  // A request that evicts the oldest sample always divides by the full
  // window size.
  a_evict_after_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_ctl.evict) |-> (q_div == CNT_W'(WINDOW_SIZE)))
    else $error("evicting request without a full window");

endmodule

// ----- design/swr_front.sv -----
// ----------------------------------------------------------------------------
// swr_front: request intake and classification
// Accepts samples, keeps the write index and fill count, tags each request
// with its store slot, its divisor and whether it evicts the oldest sample,
// and holds the tagged requests in a short queue for the back part.
// ----------------------------------------------------------------------------
module swr_front #(
  parameter int WINDOW_SIZE  = swr_pkg::DEF_WINDOW_SIZE,
  parameter int SAMPLE_WIDTH = swr_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  output logic                                        in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]              in_sample,
  output swr_pkg::swr_ctl_t                           q_ctl,
  output logic        [SAMPLE_WIDTH-1:0]              q_sample,
  output logic        [swr_pkg::idx_w(WINDOW_SIZE)-1:0] q_idx,
  output logic        [swr_pkg::cnt_w(WINDOW_SIZE)-1:0] q_div,
  input  logic                                        q_pop
);
  import swr_pkg::*;

  localparam int IDX_W = idx_w(WINDOW_SIZE);
  localparam int CNT_W = cnt_w(WINDOW_SIZE);

  logic             [IDX_W-1:0]   idx_r, idx_nxt;
  logic             [CNT_W-1:0]   fill_r, fill_nxt;
  logic             [CNT_W-1:0]   div_new;
  logic                           full;
  logic                           accept;

  logic [SAMPLE_WIDTH-1:0] q_sample_r [Q_DEPTH];
  logic [IDX_W-1:0]        q_idx_r    [Q_DEPTH];
  logic [CNT_W-1:0]        q_div_r    [Q_DEPTH];
  logic                    q_evict_r  [Q_DEPTH];
  logic [Q_PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]      count_r, count_nxt;

  // A request is taken whenever the queue has room.
  assign in_stall = (count_r == Q_CNT_W'(Q_DEPTH));
  assign accept   = in_valid && !in_stall;

  // Classification: once the window is full each new sample replaces the oldest.
  assign full    = (fill_r == CNT_W'(WINDOW_SIZE));
  assign div_new = full ? fill_r : CNT_W'(fill_r + 1'b1);

  always_comb begin
    fill_nxt = fill_r;
    idx_nxt  = idx_r;
    if (accept) begin
      fill_nxt = div_new;
      if (idx_r == IDX_W'(WINDOW_SIZE - 1)) begin
        idx_nxt = '0;
      end else begin
        idx_nxt = IDX_W'(idx_r + 1'b1);
      end
    end
  end

  // Queue pointers and occupancy.
  always_comb begin
    wr_ptr_nxt = accept ? Q_PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = q_pop  ? Q_PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = Q_CNT_W'(count_r + Q_CNT_W'(accept) - Q_CNT_W'(q_pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      fill_r   <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      idx_r    <= idx_nxt;
      fill_r   <= fill_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage carries the tagged request.
  always_ff @(posedge clk) begin
    if (accept) begin
      q_sample_r[wr_ptr_r] <= in_sample;
      q_idx_r[wr_ptr_r]    <= idx_r;
      q_div_r[wr_ptr_r]    <= div_new;
      q_evict_r[wr_ptr_r]  <= full;
    end
  end

  // Head of the queue towards the back part.
  assign q_ctl.valid = (count_r != '0);
  assign q_ctl.evict = q_evict_r[rd_ptr_r];
  assign q_sample    = q_sample_r[rd_ptr_r];
  assign q_idx       = q_idx_r[rd_ptr_r];
  assign q_div       = q_div_r[rd_ptr_r];

endmodule

// ----- design/swr_back.sv -----
// ----------------------------------------------------------------------------
// swr_back: window store, running sum and RMS sequencer
// Takes one request from the queue, swaps the sample into the window store,
// updates the sum of squares, divides by the fill count one bit a cycle,
// takes the square root two radicand bits a cycle and registers the result.
// ----------------------------------------------------------------------------
module swr_back #(
  parameter int WINDOW_SIZE  = swr_pkg::DEF_WINDOW_SIZE,
  parameter int SAMPLE_WIDTH = swr_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  swr_pkg::swr_ctl_t                           q_ctl,
  input  logic        [SAMPLE_WIDTH-1:0]              q_sample,
  input  logic        [swr_pkg::idx_w(WINDOW_SIZE)-1:0] q_idx,
  input  logic        [swr_pkg::cnt_w(WINDOW_SIZE)-1:0] q_div,
  output logic                                        q_pop,
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output logic        [SAMPLE_WIDTH-1:0]              out_rms_value,
  output logic                                        out_window_full
);
  import swr_pkg::*;

  localparam int IDX_W  = idx_w(WINDOW_SIZE);
  localparam int CNT_W  = cnt_w(WINDOW_SIZE);
  localparam int SQ_W   = 2 * SAMPLE_WIDTH - 1;
  localparam int SUM_W  = SQ_W + $clog2(WINDOW_SIZE);
  localparam int RAD_W  = 2 * SAMPLE_WIDTH;
  localparam int RW     = SAMPLE_WIDTH + 2;
  localparam int STEP_W = $clog2(SUM_W + 1);

  swr_state_t state_r, state_nxt;

  logic [SAMPLE_WIDTH-1:0] window_mem [WINDOW_SIZE];
  logic [SAMPLE_WIDTH-1:0] rd_r;
  logic                    mem_en;
  logic                    out_load;

  logic [SAMPLE_WIDTH-1:0] sample_r, sample_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [CNT_W-1:0]        div_r, div_nxt;
  logic                    evict_r, evict_nxt;
  logic [SQ_W-1:0]         sq_r, sq_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [SUM_W-1:0]        quot_r, quot_nxt;
  logic [CNT_W-1:0]        rem_r, rem_nxt;
  logic [RAD_W-1:0]        rad_r, rad_nxt;
  logic [SAMPLE_WIDTH-1:0] root_r, root_nxt;
  logic [RW-1:0]           srem_r, srem_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [SAMPLE_WIDTH-1:0] out_rms_r, out_rms_nxt;
  logic                    out_full_r, out_full_nxt;

  logic signed [SAMPLE_WIDTH-1:0]   mul_in;
  logic signed [2*SAMPLE_WIDTH-1:0] prod;
  logic        [SUM_W-1:0]          sum_added;
  logic        [CNT_W:0]            rem_sh, rem_sub;
  logic                             div_ge;
  logic        [SUM_W-1:0]          quot_step;
  logic        [RW-1:0]             srem_sh, trial, srem_sub;
  logic                             sqrt_ge;

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (q_ctl.valid) state_nxt = ST_FETCH;
      ST_FETCH:  state_nxt = ST_SQ_OLD;
      ST_SQ_OLD: state_nxt = ST_SQ_NEW;
      ST_SQ_NEW: state_nxt = ST_ACC;
      ST_ACC:    state_nxt = ST_DIV;
      ST_DIV:    if (step_r == STEP_W'(SUM_W - 1)) state_nxt = ST_SQRT;
      ST_SQRT:   if (step_r == STEP_W'(SAMPLE_WIDTH - 1)) state_nxt = ST_DONE;
      ST_DONE:   if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    q_pop    = (state_r == ST_IDLE) && q_ctl.valid;
    mem_en   = (state_r == ST_FETCH);
    out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  end

  // Window store: the old sample is read out as the new one is written.
  always_ff @(posedge clk) begin
    if (mem_en) begin
      rd_r              <= window_mem[idx_r];
      window_mem[idx_r] <= sample_r;
    end
  end

  // Shared squaring unit: the evicted sample first, then the new one.
  assign mul_in    = (state_r == ST_SQ_OLD) ? $signed(rd_r) : $signed(sample_r);
  assign prod      = mul_in * mul_in;
  assign sum_added = sum_r + SUM_W'(sq_r);

  // One restoring division step per cycle; the remainder stays below the divisor.
  assign rem_sh    = {rem_r, quot_r[SUM_W-1]};
  assign rem_sub   = rem_sh - {1'b0, div_r};
  assign div_ge    = (rem_sh >= {1'b0, div_r});
  assign quot_step = {quot_r[SUM_W-2:0], div_ge};

  // One square root digit per cycle, two radicand bits at a time.
  assign srem_sh  = {srem_r[RW-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial    = {root_r, 2'b01};
  assign srem_sub = srem_sh - trial;
  assign sqrt_ge  = (srem_sh >= trial);

  // Datapath next values.
  always_comb begin
    sample_nxt    = sample_r;
    idx_nxt       = idx_r;
    div_nxt       = div_r;
    evict_nxt     = evict_r;
    sq_nxt        = sq_r;
    sum_nxt       = sum_r;
    quot_nxt      = quot_r;
    rem_nxt       = rem_r;
    rad_nxt       = rad_r;
    root_nxt      = root_r;
    srem_nxt      = srem_r;
    step_nxt      = step_r;
    out_rms_nxt   = out_rms_r;
    out_full_nxt  = out_full_r;
    out_valid_nxt = out_load || (out_valid_r && out_stall);
    case (state_r)
      ST_IDLE: begin
        if (q_ctl.valid) begin
          sample_nxt = q_sample;
          idx_nxt    = q_idx;
          div_nxt    = q_div;
          evict_nxt  = q_ctl.evict;
        end
      end
      ST_SQ_OLD: begin
        sq_nxt = prod[SQ_W-1:0];
      end
      ST_SQ_NEW: begin
        // The evicted square leaves the sum before the new one enters.
        sum_nxt = evict_r ? SUM_W'(sum_r - SUM_W'(sq_r)) : sum_r;
        sq_nxt  = prod[SQ_W-1:0];
      end
      ST_ACC: begin
        sum_nxt  = sum_added;
        quot_nxt = sum_added;
        rem_nxt  = '0;
        step_nxt = '0;
      end
      ST_DIV: begin
        rem_nxt  = div_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        quot_nxt = quot_step;
        step_nxt = STEP_W'(step_r + 1'b1);
        if (step_r == STEP_W'(SUM_W - 1)) begin
          // The mean square never exceeds one full-scale square.
          rad_nxt  = RAD_W'(quot_step[SQ_W-1:0]);
          root_nxt = '0;
          srem_nxt = '0;
          step_nxt = '0;
        end
      end
      ST_SQRT: begin
        srem_nxt = sqrt_ge ? srem_sub : srem_sh;
        root_nxt = {root_r[SAMPLE_WIDTH-2:0], sqrt_ge};
        rad_nxt  = {rad_r[RAD_W-3:0], 2'b00};
        step_nxt = STEP_W'(step_r + 1'b1);
      end
      ST_DONE: begin
        if (out_load) begin
          out_rms_nxt  = root_r;
          out_full_nxt = (div_r == CNT_W'(WINDOW_SIZE));
        end
      end
      default: begin
      end
    endcase
  end

  // Control state and the running sum are cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
      out_full_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      out_full_r  <= out_full_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    sample_r  <= sample_nxt;
    idx_r     <= idx_nxt;
    div_r     <= div_nxt;
    evict_r   <= evict_nxt;
    sq_r      <= sq_nxt;
    quot_r    <= quot_nxt;
    rem_r     <= rem_nxt;
    rad_r     <= rad_nxt;
    root_r    <= root_nxt;
    srem_r    <= srem_nxt;
    step_r    <= step_nxt;
    out_rms_r <= out_rms_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_rms_value   = out_rms_r;
  assign out_window_full = out_full_r;

endmodule
